### rtl/cdq_pkg.sv
// Shared types and constants for the circular deque.
// Command and status codes, controller states and controller/datapath links.
// No dependencies.
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int CNT_W = 5;   // count, capacity and position width
    localparam int VAL_W = 32;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_LIST       = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LIST
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch a new command beat
        logic exec;       // carry out the latched command
        logic list_step;  // read the next listed element
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic list_go;    // latched command is a list with elements held
        logic list_end;   // this list step reads the rear element
    } t_stat;

endpackage

### rtl/cdq_ctrl.sv
// Controller of the circular deque: accepts command beats and sequences
// execution and list walks. Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_ctrl import cdq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output logic  o_busy,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = i_stat.list_go ? S_LIST : S_IDLE;
            end
            S_LIST: begin
                if (i_stat.list_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_busy         = 1'b1;
        o_ctrl.load      = 1'b0;
        o_ctrl.exec      = 1'b0;
        o_ctrl.list_step = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy      = 1'b0;
                o_ctrl.load = i_start;
            end
            S_EXEC: o_ctrl.exec = 1'b1;
            S_LIST: o_ctrl.list_step = 1'b1;
            default: o_busy = 1'b1;
        endcase
    end

endmodule

### rtl/cdq_dpath.sv
// Datapath of the circular deque: element store, head and count, capacity
// register, wrapped position unit and result registers. Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_dpath import cdq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctrl                   i_ctrl,
    output t_stat                   o_stat,
    input  logic [2:0]              i_command,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_cfg_we,
    input  logic [CNT_W-1:0]        i_cfg_data,
    output logic                    o_strobe,
    output logic [1:0]              o_status,
    output logic signed [VAL_W-1:0] o_element,
    output logic [CNT_W-1:0]        o_occupancy,
    output logic                    o_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] CAP_RST = (DEPTH < 16) ? CNT_W'(DEPTH) : CNT_W'(16);

    logic [VAL_W-1:0] mem [DEPTH];

    logic [2:0]              r_cmd;
    logic signed [VAL_W-1:0] r_value;
    logic [CNT_W-1:0]        r_cap;
    logic [CNT_W-1:0]        r_head;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_k;
    logic [VAL_W-1:0]        r_rd_data;
    logic                    r_pend;
    logic                    r_pend_last;
    logic                    r_strobe;
    logic [1:0]              r_status;
    logic [VAL_W-1:0]        r_element;
    logic [CNT_W-1:0]        r_occ;
    logic                    r_last;

    logic [CNT_W-1:0] cfg_cap;
    logic [CNT_W-1:0] offs;
    logic [CNT_W-1:0] pos;
    logic             full;
    logic             empty;
    logic             wr_en;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             list_end;

    // position k past base b, wrapped to cap (b < cap, k < 2*cap)
    function automatic logic [CNT_W-1:0] wrap_add(
        input logic [CNT_W-1:0] b,
        input logic [CNT_W-1:0] k,
        input logic [CNT_W-1:0] cap
    );
        logic [CNT_W+1:0] p;
        logic [CNT_W+1:0] c;
        c = {2'b00, cap};
        p = {2'b00, b} + {2'b00, k};
        if (p >= c) p = p - c;
        if (p >= c) p = p - c;
        return p[CNT_W-1:0];
    endfunction

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_cap = CNT_W'(1);
        end else if (32'(i_cfg_data) > DEPTH) begin
            cfg_cap = CNT_W'(DEPTH);
        end else begin
            cfg_cap = i_cfg_data;
        end
    end

    assign full     = (r_count >= r_cap);
    assign empty    = (r_count == '0);
    assign list_end = (r_k + CNT_W'(1) == r_count);

    // one shared wrap unit; the offset depends on the command
    always_comb begin
        offs = r_k;
        if (i_ctrl.exec) begin
            unique case (r_cmd)
                CMD_PUSH_FRONT: offs = r_cap - CNT_W'(1);
                CMD_PUSH_REAR:  offs = r_count;
                CMD_POP_FRONT:  offs = CNT_W'(1);
                CMD_POP_REAR:   offs = r_count - CNT_W'(1);
                default:        offs = r_k;
            endcase
        end
    end

    assign pos = wrap_add(r_head, offs, r_cap);

    always_comb begin
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = AW'(pos);
        if (i_ctrl.exec) begin
            unique case (r_cmd)
                CMD_PUSH_FRONT, CMD_PUSH_REAR: wr_en = !full;
                CMD_POP_FRONT: begin
                    rd_en   = !empty;
                    rd_addr = AW'(r_head);
                end
                CMD_POP_REAR: rd_en = !empty;
                default: rd_en = 1'b0;
            endcase
        end else if (i_ctrl.list_step) begin
            rd_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[AW'(pos)] <= r_value;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd   <= i_command;
            r_value <= i_value;
        end
    end

    // capacity, head, count and list walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RST;
            r_head  <= '0;
            r_count <= '0;
            r_k     <= '0;
        end else if (i_cfg_we) begin
            r_cap   <= cfg_cap;
            r_head  <= '0;
            r_count <= '0;
        end else if (i_ctrl.exec) begin
            r_k <= '0;
            unique case (r_cmd)
                CMD_PUSH_FRONT: begin
                    if (!full) begin
                        r_head  <= pos;
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                CMD_PUSH_REAR: begin
                    if (!full) r_count <= r_count + CNT_W'(1);
                end
                CMD_POP_FRONT: begin
                    if (!empty) begin
                        r_head  <= pos;
                        r_count <= r_count - CNT_W'(1);
                    end
                end
                CMD_POP_REAR: begin
                    if (!empty) r_count <= r_count - CNT_W'(1);
                end
                default: r_k <= '0;
            endcase
        end else if (i_ctrl.list_step) begin
            r_k <= r_k + CNT_W'(1);
        end
    end

    // read beats in flight towards the result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= rd_en;
        end
        r_pend_last <= i_ctrl.exec ? 1'b1 : list_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_pend || (i_ctrl.exec && !rd_en && !o_stat.list_go);
        end
    end

    // result payload: direct answers at execution, read data behind the registered store read
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_status  <= ST_DONE;
            r_element <= r_rd_data;
            r_occ     <= r_count;
            r_last    <= r_pend_last;
        end else if (i_ctrl.exec) begin
            r_element <= '0;
            r_last    <= 1'b1;
            unique case (r_cmd)
                CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                    r_status <= full ? ST_FULL : ST_DONE;
                    r_occ    <= full ? r_count : r_count + CNT_W'(1);
                end
                CMD_POP_FRONT, CMD_POP_REAR, CMD_LIST: begin
                    r_status <= ST_EMPTY;
                    r_occ    <= '0;
                end
                default: begin
                    r_status <= ST_DONE;
                    r_occ    <= r_count;
                end
            endcase
        end
    end

    assign o_stat.list_go  = (r_cmd == CMD_LIST) && !empty;
    assign o_stat.list_end = list_end;

    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_element   = r_element;
    assign o_occupancy = r_occ;
    assign o_last      = r_last;

endmodule

### rtl/circular_deque.sv
// Top level of the circular deque: controller plus datapath.
// Depends on cdq_pkg, cdq_ctrl and cdq_dpath.
`timescale 1ns / 1ps

// A command beat is taken when start is high and busy is low. Busy stays
// high while a command executes, so a new command is not taken before the
// current one is through; a list keeps busy high while it walks its n held
// elements one by one through the single read port of the element store,
// which returns one element per cycle. Push, refused and ignored commands
// give their result registered from the execute state; pops arrive behind
// the registered store read, and listed elements behind each list step's
// store read, one per cycle. Every result is shown for exactly one cycle on
// o_strobe and cannot be held off, so the receiver must take it then.
// Writing capacity empties the queue; write it only while idle.
module circular_deque import cdq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [2:0]              i_command,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_cfg_we,
    input  logic [CNT_W-1:0]        i_cfg_data,
    output logic                    o_strobe,
    output logic [1:0]              o_status,
    output logic signed [VAL_W-1:0] o_element,
    output logic [CNT_W-1:0]        o_occupancy,
    output logic                    o_last
);

    t_ctrl ctrl;
    t_stat stat;

    cdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_ctrl  (ctrl)
    );

    cdq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .i_command   (i_command),
        .i_value     (i_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_element   (o_element),
        .o_occupancy (o_occupancy),
        .o_last      (o_last)
    );

endmodule
